### hw/rtl/bpfs_pkg.sv
// Shared types and constants of the Blinn-Phong fragment shader.
package bpfs_pkg;

    localparam int NRM_W = 16;
    localparam int POS_W = 24;
    localparam int COL_W = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 24;

    // Normalizer: 64-bit root over 32 steps, 15-bit quotient, Q2.14 result.
    localparam int ISQ_W = 64;
    localparam int ISQ_STEPS = ISQ_W / 2;
    localparam int QUO_W = 15;
    localparam int UVEC_W = 16;
    localparam int UNIT_LAT = 2 + ISQ_STEPS + QUO_W + 1;

    localparam int K_UNIT = 30;
    localparam int K_POS = 12;
    localparam int THR_UNIT = 2;
    localparam int THR_POS = 42;
    localparam int DIVSH_UNIT = 0;
    localparam int DIVSH_POS = 2;

    localparam int SPEC_SQUARINGS_DEF = 8;

    localparam int D_W = 18;
    localparam int S_W = 19;
    localparam int F_W = 19;

    localparam logic signed [POS_W-1:0] DEF_LIGHT_Z = 24'sd655360;
    localparam logic signed [POS_W-1:0] DEF_CAMERA_Z = 24'sd327680;
    localparam logic [F_W-1:0] AMB_Q16 = 19'd9830;
    localparam logic [15:0] DIF_Q16 = 16'd45875;
    localparam logic [S_W-1:0] SPEC_CAP = 19'd262144;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LIGHT_VALID  = 3'd0,
        REG_LIGHT_X      = 3'd1,
        REG_LIGHT_Y      = 3'd2,
        REG_LIGHT_Z      = 3'd3,
        REG_CAMERA_VALID = 3'd4,
        REG_CAMERA_X     = 3'd5,
        REG_CAMERA_Y     = 3'd6,
        REG_CAMERA_Z     = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic signed [NRM_W-1:0] normal_x;
        logic signed [NRM_W-1:0] normal_y;
        logic signed [NRM_W-1:0] normal_z;
        logic signed [POS_W-1:0] frag_x;
        logic signed [POS_W-1:0] frag_y;
        logic signed [POS_W-1:0] frag_z;
        logic [COL_W-1:0]        base_red;
        logic [COL_W-1:0]        base_green;
        logic [COL_W-1:0]        base_blue;
    } frag_t;

    typedef struct packed {
        logic [COL_W-1:0] out_red;
        logic [COL_W-1:0] out_green;
        logic [COL_W-1:0] out_blue;
    } pix_t;

endpackage

### hw/rtl/bpfs_if.sv
// Channel interfaces: fragment input, pixel output, register writes.
interface bpfs_frag_if;
    logic            valid;
    logic            ready;
    bpfs_pkg::frag_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface bpfs_pix_if;
    logic           valid;
    logic           ready;
    bpfs_pkg::pix_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface bpfs_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [bpfs_pkg::CFG_IDX_W-1:0]      index;
    logic [bpfs_pkg::CFG_DATA_W-1:0]     data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### hw/rtl/bpfs_unit.sv
// Pipelined vector normalizer: squares, root step per stage, quotient bit per stage; short vectors take a shifted copy.
module bpfs_unit #(
    parameter int W = 16,
    parameter int K = 30,
    parameter int THRESH = 2,
    parameter int DIV_SH = 0
) (
    input  logic                                  clk,
    input  logic                                  en,
    input  logic signed [W-1:0]                   vec [3],
    output logic signed [bpfs_pkg::UVEC_W-1:0]    unit [3]
);

    localparam int XW = bpfs_pkg::ISQ_W;
    localparam int NS = bpfs_pkg::ISQ_STEPS;
    localparam int QW = bpfs_pkg::QUO_W;
    localparam int UW = bpfs_pkg::UVEC_W;
    localparam int RW = XW / 2;
    localparam int SH = 14 + K / 2;

    // stage A: squares, magnitude, short-vector value
    logic [W-1:0]            mag_a_reg [3];
    logic                    neg_a_reg [3];
    logic signed [UW-1:0]    sh_a_reg [3];
    logic [2*W-1:0]          sq_a_reg [3];
    logic [W-1:0]            mag_a_next [3];
    logic                    neg_a_next [3];
    logic signed [UW-1:0]    sh_a_next [3];
    logic [2*W-1:0]          sq_a_next [3];
    logic signed [2*W-1:0]   ext_a [3];
    logic signed [W:0]       bias_a [3];
    logic signed [W:0]       shv_a [3];

    // root section, index 0 is the radicand stage
    logic [XW-1:0]           x_reg [NS+1];
    logic [XW-1:0]           r_reg [NS+1];
    logic                    big_s_reg [NS+1];
    logic [W-1:0]            mag_s_reg [NS+1][3];
    logic                    neg_s_reg [NS+1][3];
    logic signed [UW-1:0]    sh_s_reg [NS+1][3];
    logic [XW-1:0]           x_next [NS+1];
    logic [XW-1:0]           r_next [NS+1];
    logic                    big_s_next [NS+1];
    logic [XW-1:0]           sum_b;
    logic [XW-1:0]           trial [NS+1];
    logic [XW-1:0]           rbit [NS+1];

    // divider section
    logic [XW-1:0]           rem_reg [QW][3];
    logic [QW-1:0]           quo_reg [QW][3];
    logic [RW-1:0]           root_reg [QW];
    logic                    big_d_reg [QW];
    logic                    neg_d_reg [QW][3];
    logic signed [UW-1:0]    sh_d_reg [QW][3];
    logic [XW-1:0]           rem_next [QW][3];
    logic [QW-1:0]           quo_next [QW][3];
    logic [XW-1:0]           rem_src [QW][3];
    logic [QW-1:0]           quo_src [QW][3];
    logic [XW-1:0]           comp [QW][3];

    logic signed [UW-1:0]    unit_reg [3];
    logic signed [UW-1:0]    unit_next [3];
    logic signed [UW-1:0]    qv [3];

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            ext_a[c] = (2*W)'(vec[c]);
            sq_a_next[c] = (2*W)'(ext_a[c] * ext_a[c]);
            neg_a_next[c] = vec[c][W-1];
            mag_a_next[c] = vec[c][W-1] ? W'(-vec[c]) : W'(vec[c]);
            // truncate toward zero
            bias_a[c] = vec[c][W-1] ? (W+1)'((1 << DIV_SH) - 1) : '0;
            shv_a[c] = ((W+1)'(vec[c]) + bias_a[c]) >>> DIV_SH;
            sh_a_next[c] = UW'(shv_a[c]);
        end

        sum_b = XW'(sq_a_reg[0]) + XW'(sq_a_reg[1]) + XW'(sq_a_reg[2]);
        x_next[0] = sum_b << K;
        r_next[0] = '0;
        big_s_next[0] = sum_b > XW'(THRESH);
        trial[0] = '0;
        rbit[0] = '0;

        for (int i = 1; i <= NS; i++)
        begin
            rbit[i] = XW'(1) << (XW - 2 * i);
            trial[i] = r_reg[i-1] + rbit[i];
            big_s_next[i] = big_s_reg[i-1];
            if (x_reg[i-1] >= trial[i])
            begin
                x_next[i] = x_reg[i-1] - trial[i];
                r_next[i] = (r_reg[i-1] >> 1) + rbit[i];
            end
            else
            begin
                x_next[i] = x_reg[i-1];
                r_next[i] = r_reg[i-1] >> 1;
            end
        end

        for (int j = 0; j < QW; j++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                if (j == 0)
                begin
                    rem_src[j][c] = XW'(mag_s_reg[NS][c]) << SH;
                    quo_src[j][c] = '0;
                    comp[j][c] = XW'(r_reg[NS][RW-1:0]) << (QW - 1 - j);
                end
                else
                begin
                    rem_src[j][c] = rem_reg[j-1][c];
                    quo_src[j][c] = quo_reg[j-1][c];
                    comp[j][c] = XW'(root_reg[j-1]) << (QW - 1 - j);
                end
                if (rem_src[j][c] >= comp[j][c])
                begin
                    rem_next[j][c] = rem_src[j][c] - comp[j][c];
                    quo_next[j][c] = quo_src[j][c] | (QW'(1) << (QW - 1 - j));
                end
                else
                begin
                    rem_next[j][c] = rem_src[j][c];
                    quo_next[j][c] = quo_src[j][c];
                end
            end
        end

        for (int c = 0; c < 3; c++)
        begin
            qv[c] = UW'(quo_reg[QW-1][c]);
            if (big_d_reg[QW-1])
                unit_next[c] = neg_d_reg[QW-1][c] ? -qv[c] : qv[c];
            else
                unit_next[c] = sh_d_reg[QW-1][c];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_a_reg <= mag_a_next;
            neg_a_reg <= neg_a_next;
            sh_a_reg <= sh_a_next;
            sq_a_reg <= sq_a_next;

            x_reg <= x_next;
            r_reg <= r_next;
            big_s_reg <= big_s_next;
            mag_s_reg[0] <= mag_a_reg;
            neg_s_reg[0] <= neg_a_reg;
            sh_s_reg[0] <= sh_a_reg;
            for (int i = 1; i <= NS; i++)
            begin
                mag_s_reg[i] <= mag_s_reg[i-1];
                neg_s_reg[i] <= neg_s_reg[i-1];
                sh_s_reg[i] <= sh_s_reg[i-1];
            end

            rem_reg <= rem_next;
            quo_reg <= quo_next;
            root_reg[0] <= r_reg[NS][RW-1:0];
            big_d_reg[0] <= big_s_reg[NS];
            neg_d_reg[0] <= neg_s_reg[NS];
            sh_d_reg[0] <= sh_s_reg[NS];
            for (int j = 1; j < QW; j++)
            begin
                root_reg[j] <= root_reg[j-1];
                big_d_reg[j] <= big_d_reg[j-1];
                neg_d_reg[j] <= neg_d_reg[j-1];
                sh_d_reg[j] <= sh_d_reg[j-1];
            end

            unit_reg <= unit_next;
        end
    end

    assign unit = unit_reg;

endmodule

### hw/rtl/blinn_phong_fragment_shade.sv
// Top level: pipelined per-fragment Blinn-Phong shading.
//
//   port   | role        | moves
//   -------+-------------+-------------------------------------------------
//   frag   | sink        | normal, world position, base color of a fragment
//   pixel  | source      | lit red, green, blue
//   cfg    | sink        | register index and write data, always ready
//
// One fragment per cycle sustained while pixel does not stall. The path runs
// through two normalizers in series, each a 32-step
// square-root pipeline followed by a 15-step quotient pipeline.
// rst_n clears the valid bits and the registers to their defaults.
// A stall on pixel freezes the whole pipeline; frag.ready drops with it.
module blinn_phong_fragment_shade #(
    parameter int SPEC_SQUARINGS = bpfs_pkg::SPEC_SQUARINGS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    bpfs_frag_if.sink    frag,
    bpfs_pix_if.source   pixel,
    bpfs_cfg_if.sink     cfg
);

    localparam int UL = bpfs_pkg::UNIT_LAT;
    localparam int SQ = SPEC_SQUARINGS;
    localparam int TOTAL = 2 * UL + SQ + 6;
    localparam int NW = bpfs_pkg::NRM_W;
    localparam int PW = bpfs_pkg::POS_W;
    localparam int UW = bpfs_pkg::UVEC_W;
    localparam int CW = bpfs_pkg::COL_W;
    localparam int DW = bpfs_pkg::D_W;
    localparam int SW = bpfs_pkg::S_W;
    localparam int FW = bpfs_pkg::F_W;

    // configuration
    logic                 light_valid_reg, camera_valid_reg;
    logic signed [PW-1:0] light_reg [3];
    logic signed [PW-1:0] camera_reg [3];
    logic signed [PW-1:0] lp [3];
    logic signed [PW-1:0] cp [3];

    logic                 en;
    logic [TOTAL-1:0]     vld_reg;
    logic [TOTAL-1:0]     vld_next;

    logic signed [NW-1:0] n0_reg [3];
    logic signed [PW:0]   l0_reg [3];
    logic signed [PW:0]   v0_reg [3];
    logic signed [PW-1:0] p_in [3];
    logic [2:0][CW-1:0]   col_reg [TOTAL-1];

    logic signed [UW-1:0] un_n [3];
    logic signed [UW-1:0] un_l [3];
    logic signed [UW-1:0] un_v [3];
    logic signed [UW-1:0] un_h [3];
    logic signed [UW:0]   h_sum [3];

    logic signed [UW-1:0] nd_reg [UL][3];
    logic signed [UW-1:0] ld_reg [UL][3];

    logic signed [31:0]   pn_reg [3];
    logic signed [31:0]   ph_reg [3];
    logic signed [31:0]   pn_next [3];
    logic signed [31:0]   ph_next [3];
    logic signed [31:0]   ma, mb, mh;

    logic signed [33:0]   dsum, hsum;
    logic [DW-1:0]        d_reg, d_next;
    logic [SW-1:0]        s_reg, s_next;
    logic [DW-1:0]        hpos;

    logic [SW-1:0]        sq_reg [SQ];
    logic [SW-1:0]        sq_next [SQ];
    logic [DW-1:0]        dd_reg [SQ];
    logic [2*SW-1:0]      sq_prod [SQ];
    logic [2*SW-1:0]      sq_in [SQ];
    logic [2*SW-17:0]     sq_sh [SQ];

    logic [34:0]          t_reg, t_next;
    logic [FW-1:0]        f_reg, f_next;
    logic [34:0]          dif_prod;

    bpfs_pkg::pix_t       out_reg, out_next;
    logic [FW+CW-1:0]     c_prod [3];
    logic [CW-1:0]        c_val [3];

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_valid_reg <= 1'b0;
            camera_valid_reg <= 1'b0;
            light_reg[0] <= '0;
            light_reg[1] <= '0;
            light_reg[2] <= bpfs_pkg::DEF_LIGHT_Z;
            camera_reg[0] <= '0;
            camera_reg[1] <= '0;
            camera_reg[2] <= bpfs_pkg::DEF_CAMERA_Z;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                bpfs_pkg::REG_LIGHT_VALID:  light_valid_reg <= cfg.data[0];
                bpfs_pkg::REG_LIGHT_X:      light_reg[0] <= cfg.data;
                bpfs_pkg::REG_LIGHT_Y:      light_reg[1] <= cfg.data;
                bpfs_pkg::REG_LIGHT_Z:      light_reg[2] <= cfg.data;
                bpfs_pkg::REG_CAMERA_VALID: camera_valid_reg <= cfg.data[0];
                bpfs_pkg::REG_CAMERA_X:     camera_reg[0] <= cfg.data;
                bpfs_pkg::REG_CAMERA_Y:     camera_reg[1] <= cfg.data;
                bpfs_pkg::REG_CAMERA_Z:     camera_reg[2] <= cfg.data;
                default: ;
            endcase
        end
    end

    // whole pipeline advances together unless the output holds an untaken pixel
    assign en = !vld_reg[TOTAL-1] || pixel.ready;
    assign frag.ready = en;
    assign vld_next = {vld_reg[TOTAL-2:0], frag.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= vld_next;
    end

    always_comb
    begin
        lp[0] = light_valid_reg ? light_reg[0] : '0;
        lp[1] = light_valid_reg ? light_reg[1] : '0;
        lp[2] = light_valid_reg ? light_reg[2] : bpfs_pkg::DEF_LIGHT_Z;
        cp[0] = camera_valid_reg ? camera_reg[0] : '0;
        cp[1] = camera_valid_reg ? camera_reg[1] : '0;
        cp[2] = camera_valid_reg ? camera_reg[2] : bpfs_pkg::DEF_CAMERA_Z;
        p_in[0] = frag.data.frag_x;
        p_in[1] = frag.data.frag_y;
        p_in[2] = frag.data.frag_z;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n0_reg[0] <= frag.data.normal_x;
            n0_reg[1] <= frag.data.normal_y;
            n0_reg[2] <= frag.data.normal_z;
            for (int i = 0; i < 3; i++)
            begin
                l0_reg[i] <= (PW+1)'(lp[i]) - (PW+1)'(p_in[i]);
                v0_reg[i] <= (PW+1)'(cp[i]) - (PW+1)'(p_in[i]);
            end
            col_reg[0] <= {frag.data.base_red, frag.data.base_green, frag.data.base_blue};
            for (int i = 1; i < TOTAL - 1; i++)
                col_reg[i] <= col_reg[i-1];
        end
    end

    bpfs_unit #(
        .W(NW), .K(bpfs_pkg::K_UNIT), .THRESH(bpfs_pkg::THR_UNIT),
        .DIV_SH(bpfs_pkg::DIVSH_UNIT)
    ) u_norm_n (.clk(clk), .en(en), .vec(n0_reg), .unit(un_n));

    bpfs_unit #(
        .W(PW + 1), .K(bpfs_pkg::K_POS), .THRESH(bpfs_pkg::THR_POS),
        .DIV_SH(bpfs_pkg::DIVSH_POS)
    ) u_norm_l (.clk(clk), .en(en), .vec(l0_reg), .unit(un_l));

    bpfs_unit #(
        .W(PW + 1), .K(bpfs_pkg::K_POS), .THRESH(bpfs_pkg::THR_POS),
        .DIV_SH(bpfs_pkg::DIVSH_POS)
    ) u_norm_v (.clk(clk), .en(en), .vec(v0_reg), .unit(un_v));

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            h_sum[i] = (UW+1)'(un_l[i]) + (UW+1)'(un_v[i]);
    end

    bpfs_unit #(
        .W(UW + 1), .K(bpfs_pkg::K_UNIT), .THRESH(bpfs_pkg::THR_UNIT),
        .DIV_SH(bpfs_pkg::DIVSH_UNIT)
    ) u_norm_h (.clk(clk), .en(en), .vec(h_sum), .unit(un_h));

    // N and L wait alongside the half-vector normalizer
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nd_reg[0] <= un_n;
            ld_reg[0] <= un_l;
            for (int j = 1; j < UL; j++)
            begin
                nd_reg[j] <= nd_reg[j-1];
                ld_reg[j] <= ld_reg[j-1];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ma = 32'(nd_reg[UL-1][i]);
            mb = 32'(ld_reg[UL-1][i]);
            mh = 32'(un_h[i]);
            pn_next[i] = ma * mb;
            ph_next[i] = ma * mh;
        end
        dsum = 34'(pn_reg[0]) + 34'(pn_reg[1]) + 34'(pn_reg[2]);
        hsum = 34'(ph_reg[0]) + 34'(ph_reg[1]) + 34'(ph_reg[2]);
        // Q28 down to Q16; negative dot products give zero
        d_next = (dsum > 0) ? dsum[DW+11:12] : '0;
        hpos = (hsum > 0) ? hsum[DW+11:12] : '0;
        s_next = (SW'(hpos) > bpfs_pkg::SPEC_CAP) ? bpfs_pkg::SPEC_CAP : SW'(hpos);

        for (int j = 0; j < SQ; j++)
        begin
            sq_in[j] = (j == 0) ? (2*SW)'(s_reg) : (2*SW)'(sq_reg[j-1]);
            sq_prod[j] = sq_in[j] * sq_in[j];
            sq_sh[j] = sq_prod[j][2*SW-1:16];
            sq_next[j] = (sq_sh[j] > (2*SW-16)'(bpfs_pkg::SPEC_CAP))
                ? bpfs_pkg::SPEC_CAP : sq_sh[j][SW-1:0];
        end

        dif_prod = 35'(bpfs_pkg::DIF_Q16) * 35'(dd_reg[SQ-1]);
        t_next = dif_prod + (35'(sq_reg[SQ-1]) << 15);
        f_next = bpfs_pkg::AMB_Q16 + t_reg[34:16];

        for (int i = 0; i < 3; i++)
        begin
            c_prod[i] = (FW+CW)'(f_reg) * (FW+CW)'(col_reg[TOTAL-2][2-i]);
            c_val[i] = (c_prod[i][FW+CW-1:16] > (FW+CW-16)'(255))
                ? 8'd255 : c_prod[i][CW+15:16];
        end
        out_next.out_red = c_val[0];
        out_next.out_green = c_val[1];
        out_next.out_blue = c_val[2];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pn_reg <= pn_next;
            ph_reg <= ph_next;
            d_reg <= d_next;
            s_reg <= s_next;
            sq_reg <= sq_next;
            dd_reg[0] <= d_reg;
            for (int j = 1; j < SQ; j++)
                dd_reg[j] <= dd_reg[j-1];
            t_reg <= t_next;
            f_reg <= f_next;
            out_reg <= out_next;
        end
    end

    assign pixel.valid = vld_reg[TOTAL-1];
    assign pixel.data = out_reg;

endmodule
